FILE: sv/rar_pkg.sv
// Shared types and constants for the rational arithmetic reduce unit.
package rar_pkg;

  localparam int unsigned OpW  = 16;
  localparam int unsigned NumW = 2 * OpW + 1;
  localparam int unsigned DenW = 2 * OpW;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]            cmd;
    logic signed [OpW-1:0] num_a;
    logic signed [OpW-1:0] den_a;
    logic signed [OpW-1:0] num_b;
    logic signed [OpW-1:0] den_b;
  } req_t;

  typedef struct packed {
    logic signed [NumW-1:0] num_out;
    logic signed [DenW-1:0] den_out;
  } rsp_t;

  // front-end output: unreduced signed values
  typedef struct packed {
    logic signed [NumW-1:0] n;
    logic signed [DenW-1:0] d;
  } frac_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } back_state_e;

endpackage

FILE: sv/rational_arith_reduce_unit.sv
// Top level of the rational arithmetic reduce unit.
// A request passes the front stages, the queue, the load into the back end,
// the GCD steps and the two serial divides, numerator then denominator.
// Throughput: one request per back-end run; the GCD loop and the serial
// divider set it. The front end and queue absorb up to four requests.
// Reset: asynchronous, active low; clears all valid and state flags.
module rational_arith_reduce_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rar_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rar_pkg::rsp_t out_rsp_o
);
  logic f_valid, f_stall, q_valid, q_stall;
  rar_pkg::frac_t f_frac, q_frac;

  rar_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .f_valid_o(f_valid), .f_stall_i(f_stall), .f_frac_o(f_frac)
  );

  rar_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_data_i(f_frac),
    .rd_valid_o(q_valid), .rd_stall_i(q_stall), .rd_data_o(q_frac)
  );

  rar_back u_back (
    .clk_i, .rst_ni,
    .b_valid_i(q_valid), .b_stall_o(q_stall), .b_frac_i(q_frac),
    .out_valid_o, .out_stall_i, .out_rsp_o
  );
endmodule

FILE: sv/rar_front.sv
// Front end: cross-multiplication products, then their sum or difference for add and subtract; two stages.
module rar_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rar_pkg::req_t  in_req_i,
  output logic           f_valid_o,
  input  logic           f_stall_i,
  output rar_pkg::frac_t f_frac_o
);
  localparam int unsigned PW = 2 * rar_pkg::OpW;

  logic                            s1_valid_q, s1_valid_d;
  logic [1:0]                      s1_cmd_q;
  logic signed [PW-1:0]            p0_q, p1_q, p2_q;
  logic                            s2_valid_q, s2_valid_d;
  rar_pkg::frac_t                  s2_q, s2_d;
  logic                            adv2, adv1;
  logic signed [rar_pkg::OpW-1:0]  m0a, m0b, m2a, m2b;

  assign adv2 = !s2_valid_q || !f_stall_i;
  assign adv1 = !s1_valid_q || adv2;
  assign in_stall_o = !adv1;
  assign f_valid_o = s2_valid_q;
  assign f_frac_o = s2_q;

  always_comb begin
    m0a = in_req_i.num_a;
    m0b = in_req_i.den_b;
    m2a = in_req_i.den_a;
    m2b = in_req_i.den_b;
    if (in_req_i.cmd == rar_pkg::CMD_MUL) begin
      m0b = in_req_i.num_b;
    end
    if (in_req_i.cmd == rar_pkg::CMD_DIV) begin
      m2b = in_req_i.num_b;
    end
  end

  assign s1_valid_d = adv1 ? in_valid_i : s1_valid_q;

  always_comb begin
    logic signed [rar_pkg::NumW-1:0] a0, a1;
    a0 = rar_pkg::NumW'(p0_q);
    a1 = rar_pkg::NumW'(p1_q);
    s2_d.d = p2_q;
    case (rar_pkg::cmd_e'(s1_cmd_q))
      rar_pkg::CMD_ADD: s2_d.n = a0 + a1;
      rar_pkg::CMD_SUB: s2_d.n = a0 - a1;
      default:          s2_d.n = a0;
    endcase
  end

  assign s2_valid_d = adv2 ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      s1_cmd_q <= in_req_i.cmd;
      p0_q <= m0a * m0b;
      p1_q <= in_req_i.num_b * in_req_i.den_a;
      p2_q <= m2a * m2b;
    end
    if (adv2 && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end
endmodule

FILE: sv/rar_fifo.sv
// Two-entry queue between front and back ends.
module rar_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_stall_o,
  input  rar_pkg::frac_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_stall_i,
  output rar_pkg::frac_t rd_data_o
);
  rar_pkg::frac_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           wr, rd;

  assign wr_stall_o = cnt_q == 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_valid_o && !rd_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

FILE: sv/rar_back.sv
// Back end: binary GCD of the magnitudes, then two restoring divides.
module rar_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           b_valid_i,
  output logic           b_stall_o,
  input  rar_pkg::frac_t b_frac_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rar_pkg::rsp_t  out_rsp_o
);
  localparam int unsigned MW = rar_pkg::NumW - 1;  // magnitude width
  localparam int unsigned CW = $clog2(MW + 1);

  rar_pkg::back_state_e st_q, st_d;
  logic [MW-1:0] u_q, v_q, mn_q, md_q, g_q, quo_q, rem_q, dvd_q;
  logic [CW-1:0] sh_q, cnt_q;
  logic          sn_q, sd_q;
  rar_pkg::rsp_t rsp_q;
  logic          load, done_num;
  logic [MW:0]   trial;
  logic [MW-1:0] diff;

  assign b_stall_o = st_q != rar_pkg::ST_IDLE;
  assign load = b_valid_i && st_q == rar_pkg::ST_IDLE;
  assign out_valid_o = st_q == rar_pkg::ST_OUT;
  assign out_rsp_o = rsp_q;
  assign trial = {rem_q, dvd_q[MW-1]} - {1'b0, g_q};
  assign diff = (u_q > v_q) ? u_q - v_q : v_q - u_q;
  assign done_num = cnt_q == CW'(MW - 1);

  always_comb begin
    st_d = st_q;
    case (st_q)
      rar_pkg::ST_IDLE: if (b_valid_i) st_d = rar_pkg::ST_GCD;
      rar_pkg::ST_GCD:  if (v_q == '0 || u_q == v_q) st_d = rar_pkg::ST_DIVN;
      rar_pkg::ST_DIVN: if (done_num) st_d = rar_pkg::ST_DIVD;
      rar_pkg::ST_DIVD: if (done_num) st_d = rar_pkg::ST_OUT;
      rar_pkg::ST_OUT:  if (!out_stall_i) st_d = rar_pkg::ST_IDLE;
      default:          st_d = rar_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= rar_pkg::ST_IDLE;
    else         st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    logic [MW-1:0] an, ad;
    logic [MW:0]   nq;
    an = b_frac_i.n[MW] ? MW'(-b_frac_i.n) : b_frac_i.n[MW-1:0];
    ad = b_frac_i.d[MW-1] ? -b_frac_i.d : b_frac_i.d;
    case (st_q)
      rar_pkg::ST_IDLE: if (load) begin
        sn_q <= b_frac_i.n[MW];
        sd_q <= b_frac_i.d[MW-1];
        mn_q <= an;
        md_q <= ad;
        // a zero magnitude forces divisor 1
        u_q <= (an == '0 || ad == '0) ? MW'(1) : an;
        v_q <= (an == '0 || ad == '0) ? MW'(1) : ad;
        sh_q <= '0;
      end
      rar_pkg::ST_GCD: begin
        if (v_q == '0 || u_q == v_q) begin
          g_q <= u_q << sh_q;
          dvd_q <= mn_q;
          rem_q <= '0;
          cnt_q <= '0;
        end else if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          sh_q <= sh_q + 1'b1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else begin
          u_q <= (u_q < v_q) ? u_q : v_q;
          v_q <= diff >> 1;
        end
      end
      rar_pkg::ST_DIVN, rar_pkg::ST_DIVD: begin
        nq = {quo_q, ~trial[MW]};
        rem_q <= trial[MW] ? {rem_q[MW-2:0], dvd_q[MW-1]} : trial[MW-1:0];
        dvd_q <= dvd_q << 1;
        quo_q <= nq[MW-1:0];
        cnt_q <= cnt_q + 1'b1;
        if (done_num) begin
          cnt_q <= '0;
          rem_q <= '0;
          dvd_q <= md_q;
          if (st_q == rar_pkg::ST_DIVN)
            rsp_q.num_out <= sn_q ? -{1'b0, nq[MW-1:0]} : {1'b0, nq[MW-1:0]};
          else
            rsp_q.den_out <= sd_q ? -nq[MW-1:0] : nq[MW-1:0];
        end
      end
      default: ;
    endcase
  end
endmodule

FILE: sv/rar_checker.sv
// Port-level checker for the rational arithmetic reduce unit, with bind.
module rar_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input rar_pkg::rsp_t out_rsp_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result dropped or changed while stalled");

  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(out_rsp_o))
    else $error("unknown bits in result");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i)
    else $error("request withdrawn while stalled");

  a_no_back2back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("result repeated");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result after reset");
endmodule

bind rational_arith_reduce_unit rar_checker u_rar_checker (.*);
